[src/silm_pkg.sv]
package silm_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int VALUE_W    = 32;

   localparam logic [1:0] MODE_INSERT_FIRST  = 2'd0;
   localparam logic [1:0] MODE_INSERT_SECOND = 2'd1;
   localparam logic [1:0] MODE_MERGE         = 2'd2;
   localparam logic [1:0] MODE_UNUSED        = 2'd3;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_MERGE    = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

endpackage

[src/silm_ram.sv]
module silm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sorted_insert_two_list_merge_core.sv]
// Insert: an empty store or a full one needs no scan; otherwise each held value larger
// than the new one is read and shifted up one slot in turn, at a pace set by the single
// read port of the store RAM. Merge: the item is taken, then each value is read from RAM
// and then compared and emitted; an empty merge reads nothing. One item at a time; a
// finished result waits in the output register while the next item is taken. Synchronous
// active-high reset clears the counts and the control state; RAM contents are not cleared.
module sorted_insert_two_list_merge_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  silm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output silm_pkg::rsp_type rsp_data
);

   localparam int AW = silm_pkg::ADDR_W;
   localparam int CW = silm_pkg::CNT_W;
   localparam int VW = silm_pkg::VALUE_W;

   // Controller states.
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
   localparam logic [2:0] ST_INS  = 3'd1;  // shifting larger values up one slot
   localparam logic [2:0] ST_PUT  = 3'd2;  // new value lands in slot zero
   localparam logic [2:0] ST_OUT  = 3'd3;  // status result waits for the output register
   localparam logic [2:0] ST_MRD  = 3'd4;  // merge: heads are being read
   localparam logic [2:0] ST_MSEL = 3'd5;  // merge: compare heads and emit

   logic [2:0]          state_ff, state_in;
   logic                sel_ff, sel_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       cnt_a_ff, cnt_a_in;
   logic [CW-1:0]       cnt_b_ff, cnt_b_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [1:0]          st_ff, st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   silm_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic          wr_a, wr_b, wr_en;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [VW-1:0] wr_data, rd_a, rd_b;

   logic          slot_free;
   logic [CW-1:0] n_sel, n_m1, pos_m1, pos_m2;
   logic [VW-1:0] head;
   logic          take_a, is_last;
   logic [CW:0]   emitted, total;

   silm_ram #(.WIDTH(VW), .DEPTH(silm_pkg::LIST_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   silm_ram #(.WIDTH(VW), .DEPTH(silm_pkg::LIST_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign n_sel  = req_data.mode[0] ? cnt_b_ff : cnt_a_ff;
   assign n_m1   = n_sel - CW'(1);
   assign pos_m1 = pos_ff - CW'(1);
   assign pos_m2 = pos_ff - CW'(2);
   assign head   = sel_ff ? rd_b : rd_a;

   // Equal heads go to the first store, so merged order is stable.
   assign take_a  = (j_ff >= cnt_b_ff) ||
                    ((i_ff < cnt_a_ff) && ($signed(rd_a) <= $signed(rd_b)));
   assign emitted = {1'b0, i_ff} + {1'b0, j_ff} + (CW+1)'(1);
   assign total   = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign is_last = (emitted == total);

   assign wr_a = wr_en && !sel_in;
   assign wr_b = wr_en && sel_in;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = val_ff;
      rd_addr_a    = i_ff[AW-1:0];
      rd_addr_b    = j_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  silm_pkg::MODE_INSERT_FIRST, silm_pkg::MODE_INSERT_SECOND: begin
                     sel_in = req_data.mode[0];
                     val_in = req_data.value;
                     pos_in = n_sel;
                     if (n_sel == CW'(silm_pkg::LIST_DEPTH)) begin
                        st_in    = silm_pkg::STATUS_DROPPED;
                        state_in = ST_OUT;
                     end else if (n_sel == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = req_data.value;
                        if (req_data.mode[0]) begin
                           cnt_b_in = cnt_b_ff + CW'(1);
                        end else begin
                           cnt_a_in = cnt_a_ff + CW'(1);
                        end
                        st_in    = silm_pkg::STATUS_INSERTED;
                        state_in = ST_OUT;
                     end else begin
                        // Start the scan at the top occupied slot.
                        rd_addr_a = n_m1[AW-1:0];
                        rd_addr_b = n_m1[AW-1:0];
                        state_in  = ST_INS;
                     end
                  end
                  silm_pkg::MODE_MERGE: begin
                     i_in = '0;
                     j_in = '0;
                     if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                        st_in    = silm_pkg::STATUS_EMPTY;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_MRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS: begin
            // head holds slot pos-1; the write to slot pos never meets the next read.
            if ($signed(head) > val_ff) begin
               wr_en   = 1'b1;
               wr_data = head;
               pos_in  = pos_m1;
               if (pos_ff == CW'(1)) begin
                  state_in = ST_PUT;
               end else begin
                  rd_addr_a = pos_m2[AW-1:0];
                  rd_addr_b = pos_m2[AW-1:0];
               end
            end else begin
               wr_en = 1'b1;
               if (sel_ff) begin
                  cnt_b_in = cnt_b_ff + CW'(1);
               end else begin
                  cnt_a_in = cnt_a_ff + CW'(1);
               end
               st_in    = silm_pkg::STATUS_INSERTED;
               state_in = ST_OUT;
            end
         end

         ST_PUT: begin
            wr_en = 1'b1;
            if (sel_ff) begin
               cnt_b_in = cnt_b_ff + CW'(1);
            end else begin
               cnt_a_in = cnt_a_ff + CW'(1);
            end
            st_in    = silm_pkg::STATUS_INSERTED;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = '0;
               rsp_data_in.status       = st_ff;
               rsp_data_in.last         = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         ST_MRD: begin
            state_in = ST_MSEL;
         end

         ST_MSEL: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = take_a ? rd_a : rd_b;
               rsp_data_in.status       = silm_pkg::STATUS_MERGE;
               rsp_data_in.last         = is_last;
               if (take_a) begin
                  i_in = i_ff + CW'(1);
               end else begin
                  j_in = j_ff + CW'(1);
               end
               if (is_last) begin
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MRD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/silm_checker.sv]
`timescale 1ns / 1ps

module silm_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  silm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  silm_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                merge_value_count
);

   logic signed [silm_pkg::VALUE_W-1:0] first_store[$];
   logic signed [silm_pkg::VALUE_W-1:0] second_store[$];
   silm_pkg::rsp_type                   expected_rsps[$];

   assign pending_count = expected_rsps.size();

   // Puts a value after every held value that is not larger.
   function automatic void store_insert(ref logic signed [silm_pkg::VALUE_W-1:0] store[$],
                                        input logic signed [silm_pkg::VALUE_W-1:0] v);
      int pos;
      pos = store.size();
      while (pos > 0 && store[pos-1] > v) pos--;
      store.insert(pos, v);
   endfunction

   function automatic silm_pkg::rsp_type make_rsp(logic signed [silm_pkg::VALUE_W-1:0] v,
                                                  logic [1:0] st, logic lst);
      silm_pkg::rsp_type r;
      r.result_value = v;
      r.status = st;
      r.last = lst;
      return r;
   endfunction

   task automatic predict_item(silm_pkg::req_type item);
      int i;
      int j;
      int total;
      if (item.mode == silm_pkg::MODE_INSERT_FIRST ||
          item.mode == silm_pkg::MODE_INSERT_SECOND) begin
         if (item.mode == silm_pkg::MODE_INSERT_FIRST &&
             first_store.size() < silm_pkg::LIST_DEPTH) begin
            store_insert(first_store, item.value);
            expected_rsps.push_back(make_rsp('0, silm_pkg::STATUS_INSERTED, 1'b1));
         end else if (item.mode == silm_pkg::MODE_INSERT_SECOND &&
                      second_store.size() < silm_pkg::LIST_DEPTH) begin
            store_insert(second_store, item.value);
            expected_rsps.push_back(make_rsp('0, silm_pkg::STATUS_INSERTED, 1'b1));
         end else begin
            expected_rsps.push_back(make_rsp('0, silm_pkg::STATUS_DROPPED, 1'b1));
         end
      end else if (item.mode == silm_pkg::MODE_MERGE) begin
         total = first_store.size() + second_store.size();
         if (total == 0) begin
            expected_rsps.push_back(make_rsp('0, silm_pkg::STATUS_EMPTY, 1'b1));
         end else begin
            i = 0;
            j = 0;
            // Ties go to the first store.
            while (i + j < total) begin
               if (j >= second_store.size() ||
                   (i < first_store.size() && first_store[i] <= second_store[j])) begin
                  expected_rsps.push_back(make_rsp(first_store[i], silm_pkg::STATUS_MERGE,
                                                   i + j + 1 == total));
                  i++;
               end else begin
                  expected_rsps.push_back(make_rsp(second_store[j], silm_pkg::STATUS_MERGE,
                                                   i + j + 1 == total));
                  j++;
               end
            end
         end
         first_store.delete();
         second_store.delete();
      end
   endtask

   always @(posedge clock) begin
      silm_pkg::rsp_type want;
      if (reset) begin
         first_store.delete();
         second_store.delete();
         expected_rsps.delete();
         mismatch_count <= 0;
         merge_value_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: value %0d status %0d last %0d",
                           rsp_data.result_value, rsp_data.status, rsp_data.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.status == silm_pkg::STATUS_MERGE)
                  merge_value_count <= merge_value_count + 1;
               if (rsp_data !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected value %0d status %0d last %0d, got %0d %0d %0d",
                              want.result_value, want.status, want.last,
                              rsp_data.result_value, rsp_data.status, rsp_data.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_item(req_data);
      end
   end
endmodule

[tb/sorted_insert_two_list_merge_core_test.sv]
`timescale 1ns / 1ps

module sorted_insert_two_list_merge_core_test;

   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   silm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   silm_pkg::rsp_type rsp_data;
   int                mismatch_count;
   int                pending_count;
   int                merge_value_count;
   int                idle_cycles = 0;
   int                items_sent = 0;
   int                merges_sent = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_insert_two_list_merge_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   silm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .merge_value_count(merge_value_count)
   );

   // The watchdog counts cycles in which no item moves on either channel. The slowest
   // legitimate gap is the longest sender pause plus the longest receiver stall plus a
   // full-store insert shift, so the limit leaves a wide margin.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // The receiver stalls a random number of cycles before each result, and some
   // stretches take results back to back so every phase of a merge sees both cases.
   initial begin
      int stall;
      int burst;
      burst = 0;
      @(posedge clock iff !reset);
      forever begin
         if (burst > 0) begin
            stall = 0;
            burst--;
         end else begin
            stall = $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
      end
   end

   // Sends one item after a random gap and holds it until the block takes it.
   // The valid is only lowered after acceptance if a gap follows, so it never
   // gets two assignments in one step.
   task automatic send_item(logic [1:0] mode, logic signed [silm_pkg::VALUE_W-1:0] value,
                            bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.mode <= mode;
      req_data.value <= value;
      @(posedge clock iff req_ready);
      items_sent++;
      if (mode == silm_pkg::MODE_MERGE) merges_sent++;
   endtask

   function automatic logic signed [silm_pkg::VALUE_W-1:0] pick_value(int range_sel);
      case (range_sel)
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   initial begin
      int n;
      int narrow;
      logic [1:0] mode;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: an empty merge, extremes and ties across both stores,
      // the unused mode, and a merge with values from both stores.
      send_item(silm_pkg::MODE_MERGE, 32'sd0);
      send_item(silm_pkg::MODE_INSERT_FIRST, 32'sh7fffffff);
      send_item(silm_pkg::MODE_INSERT_FIRST, 32'sh80000000);
      send_item(silm_pkg::MODE_INSERT_SECOND, 32'sh80000000);
      send_item(silm_pkg::MODE_INSERT_SECOND, 32'sd0);
      send_item(silm_pkg::MODE_INSERT_FIRST, 32'sd0);
      send_item(silm_pkg::MODE_INSERT_SECOND, -32'sd1);
      send_item(silm_pkg::MODE_INSERT_FIRST, 32'sh7fffffff);
      send_item(silm_pkg::MODE_UNUSED, 32'sh5a5a5a5a);
      send_item(silm_pkg::MODE_MERGE, 32'shffffffff);
      send_item(silm_pkg::MODE_MERGE, 32'sd0);
      send_item(silm_pkg::MODE_INSERT_SECOND, 32'sh12345678);
      send_item(silm_pkg::MODE_MERGE, 32'sd0);

      // Fill the first store past full so the drop case is seen, then merge.
      for (int k = 0; k < silm_pkg::LIST_DEPTH + 2; k++)
         send_item(silm_pkg::MODE_INSERT_FIRST, $signed($urandom()), 1'b1);
      send_item(silm_pkg::MODE_MERGE, 32'sd0);

      // Let every result drain before the random part. One edge passes first so
      // the checker has already predicted the last item.
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);

      // Random part: runs of inserts into both stores with narrow or wide values,
      // closed by a merge; some runs overfill a store, a few items use mode 3.
      while (items_sent < 410) begin
         n = $urandom_range(0, 40);
         narrow = $urandom_range(0, 1);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 30) == 0) mode = silm_pkg::MODE_UNUSED;
            else mode = 2'($urandom_range(0, 1));
            send_item(mode, pick_value(narrow ? 2 : $urandom_range(0, 5)));
         end
         send_item(silm_pkg::MODE_MERGE, $signed($urandom()));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (100) @(posedge clock);

      $display("sent %0d items including %0d merges; %0d merged values checked",
               items_sent, merges_sent, merge_value_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

[files.f]
src/silm_pkg.sv
src/silm_ram.sv
src/sorted_insert_two_list_merge_core.sv
tb/silm_checker.sv
tb/sorted_insert_two_list_merge_core_test.sv
